// ===== hdl/waveform_peak_finder_assert.svh =====
// assertion macros shared by the peak finder modules
`ifndef WAVEFORM_PEAK_FINDER_ASSERT_SVH
`define WAVEFORM_PEAK_FINDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WPF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peak finder check failed");

// next-cycle implication, checked outside reset
`define WPF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peak finder check failed");

`endif

// ===== hdl/wpf_pkg.sv =====
// shared types and constants of the waveform peak finder
package wpf_pkg;

  localparam int DEF_MAX_PEAKS   = 200;
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int QDEPTH     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 12;
  localparam int HGT_W      = 16;
  localparam int CNT_W      = 8;

  localparam logic [POS_W-1:0] WIN_END_RST = 12'hFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMP_THR   = 3'd0,
    REG_PROM_THR  = 3'd1,
    REG_SLOPE_THR = 3'd2,
    REG_CURV_THR  = 3'd3,
    REG_WIN_START = 3'd4,
    REG_WIN_END   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [14:0] amp_thr;
    logic signed [15:0] prom_thr;
    logic signed [15:0] slope_thr;
    logic signed [15:0] curv_thr;
    logic [POS_W-1:0]   win_start;
    logic [POS_W-1:0]   win_end;
  } cfg_t;

  typedef struct packed {
    logic                    pv;
    logic [POS_W-1:0]        pos;
    logic signed [HGT_W-1:0] hgt;
    logic [CNT_W-1:0]        cnt;
    logic                    eol;
  } word_t;

  typedef struct packed {
    logic                    has_emit;
    logic [POS_W-1:0]        emit_pos;
    logic signed [HGT_W-1:0] emit_hgt;
    logic                    has_fin;
    logic                    fin_pv;
    logic [POS_W-1:0]        fin_pos;
    logic signed [HGT_W-1:0] fin_hgt;
    logic [CNT_W-1:0]        count;
  } rec_t;

endpackage

// ===== hdl/wpf_front.sv =====
// front end: sample window, candidate tests and pending peak merge
module wpf_front #(
  parameter int MAX_PEAKS   = wpf_pkg::DEF_MAX_PEAKS,
  parameter int MAX_SAMPLES = wpf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = wpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wpf_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_amplitude,
  input  logic signed [SAMPLE_BITS-1:0] in_slope,
  input  logic signed [SAMPLE_BITS-1:0] in_curvature,
  input  logic                          in_last,
  input  logic                          q_full,
  output logic                          q_push,
  output wpf_pkg::rec_t                 q_rec
);
  import wpf_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES + 3);
  localparam int PW = $clog2(MAX_SAMPLES);
  localparam int BW = (IW > POS_W) ? IW : POS_W;
  localparam int AW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 3;
  localparam int CW = $clog2(MAX_PEAKS + 1);
  localparam int KW = (CW > CNT_W) ? CW : CNT_W + 1;

  logic signed [SAMPLE_BITS-1:0] a0_r, a1_r, s0_r, s1_r, c_r;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [PW-1:0]                 pend_pos_r, pend_pos_nxt;
  logic signed [SAMPLE_BITS-1:0] pend_hgt_r, pend_hgt_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [CW-1:0]                 found_r, found_nxt;
  logic                          stopped_r, stopped_nxt;

  logic                 accept, judge, cand, adj, fresh;
  logic [IW-1:0]        bin;
  logic [BW-1:0]        bin_b, ws_b, we_b, old_pos_b, new_pos_b;
  logic signed [AW-1:0] a_s, p_s, n_s, s0_s, s1_s, sn_s, c_s;
  logic signed [AW-1:0] at_s, pt_s, st_s, ct_s, prom_s, old_hgt_s, new_hgt_s;
  logic [KW-1:0]        cnt_k;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  assign a_s  = AW'(a0_r);
  assign p_s  = AW'(a1_r);
  assign n_s  = AW'(in_amplitude);
  assign s0_s = AW'(s0_r);
  assign s1_s = AW'(s1_r);
  assign sn_s = AW'(in_slope);
  assign c_s  = AW'(c_r);
  assign at_s = signed'(AW'(cfg.amp_thr));
  assign pt_s = AW'(cfg.prom_thr);
  assign st_s = AW'(cfg.slope_thr);
  assign ct_s = AW'(cfg.curv_thr);
  assign prom_s = (a_s <<< 1) - p_s - n_s;

  assign judge = (idx_r >= IW'(2)) && !stopped_r;
  assign bin   = idx_r - IW'(2);
  assign bin_b = BW'(bin);
  assign ws_b  = BW'(cfg.win_start);
  assign we_b  = BW'(cfg.win_end);

  assign cand = judge && (bin < IW'(MAX_SAMPLES)) && (a_s > at_s) &&
                (prom_s > (pt_s <<< 1)) && (s0_s < st_s) &&
                ((s1_s > st_s) || (sn_s < st_s)) && (c_s < ct_s) &&
                (bin_b >= ws_b) && (bin_b <= we_b);
  assign adj   = pend_v_r && (bin == IW'(pend_pos_r) + IW'(1));
  assign fresh = cand && !adj;

  always_comb begin
    pend_pos_nxt = cand ? bin[PW-1:0] : pend_pos_r;
    pend_hgt_nxt = cand ? a0_r : pend_hgt_r;
    pend_v_nxt   = pend_v_r || cand;
    found_nxt    = fresh ? found_r + CW'(1) : found_r;
    stopped_nxt  = stopped_r || (fresh && (found_nxt >= CW'(MAX_PEAKS)));
    idx_nxt      = (idx_r < IW'(MAX_SAMPLES + 2)) ? idx_r + IW'(1) : idx_r;
  end

  // peak fields reduced to the result word widths
  assign old_pos_b = BW'(pend_pos_r);
  assign new_pos_b = BW'(pend_pos_nxt);
  assign old_hgt_s = AW'(pend_hgt_r);
  assign new_hgt_s = AW'(pend_hgt_nxt);
  assign cnt_k     = KW'(found_nxt);

  always_comb begin
    q_rec.has_emit = fresh && pend_v_r;
    q_rec.emit_pos = old_pos_b[POS_W-1:0];
    q_rec.emit_hgt = old_hgt_s[HGT_W-1:0];
    q_rec.has_fin  = in_last;
    q_rec.fin_pv   = pend_v_nxt;
    q_rec.fin_pos  = pend_v_nxt ? new_pos_b[POS_W-1:0] : '0;
    q_rec.fin_hgt  = pend_v_nxt ? new_hgt_s[HGT_W-1:0] : '0;
    q_rec.count    = (cnt_k > KW'(255)) ? 8'hFF : cnt_k[CNT_W-1:0];
  end

  assign q_push = accept && (in_last || (fresh && pend_v_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      pend_v_r  <= 1'b0;
      found_r   <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        idx_r     <= '0;
        pend_v_r  <= 1'b0;
        found_r   <= '0;
        stopped_r <= 1'b0;
      end else begin
        idx_r     <= idx_nxt;
        pend_v_r  <= pend_v_nxt;
        found_r   <= found_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1_r       <= a0_r;
      a0_r       <= in_amplitude;
      s1_r       <= s0_r;
      s0_r       <= in_slope;
      c_r        <= in_curvature;
      pend_pos_r <= pend_pos_nxt;
      pend_hgt_r <= pend_hgt_nxt;
    end
  end

endmodule

// ===== hdl/wpf_queue.sv =====
// record queue between front end and output stage
`include "waveform_peak_finder_assert.svh"
module wpf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wpf_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output wpf_pkg::rec_t q_rec
);
  import wpf_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  rec_t              slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_QW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_rec   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_QW'(push) - CNT_QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  `WPF_ASSERT_IMP(a_no_push_full, push, !full)
  `WPF_ASSERT_IMP(a_no_pop_empty, pop, q_valid)
  `WPF_ASSERT_NXT(a_fill_step, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// ===== hdl/wpf_back.sv =====
// output stage: unpacks records into result words behind an output register
`include "waveform_peak_finder_assert.svh"
module wpf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  wpf_pkg::rec_t  q_rec,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output wpf_pkg::word_t out_word
);
  import wpf_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  logic  hold_r, hold_nxt;
  word_t out_word_r, out_word_nxt;
  word_t hold_word_r, hold_word_nxt;
  word_t emit_w, fin_w;
  logic  load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !hold_r && q_valid;

  always_comb begin
    emit_w.pv  = 1'b1;
    emit_w.pos = q_rec.emit_pos;
    emit_w.hgt = q_rec.emit_hgt;
    emit_w.cnt = q_rec.count;
    emit_w.eol = 1'b0;
    fin_w.pv   = q_rec.fin_pv;
    fin_w.pos  = q_rec.fin_pos;
    fin_w.hgt  = q_rec.fin_hgt;
    fin_w.cnt  = q_rec.count;
    fin_w.eol  = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    hold_nxt      = hold_r;
    hold_word_nxt = hold_word_r;
    if (load) begin
      priority if (hold_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = hold_word_r;
        hold_nxt      = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        if (q_rec.has_emit) begin
          out_word_nxt  = emit_w;
          hold_nxt      = q_rec.has_fin;
          hold_word_nxt = fin_w;
        end else begin
          out_word_nxt = fin_w;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    hold_word_r <= hold_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `WPF_ASSERT_IMP(a_hold_behind_peak, hold_r, out_valid_r && out_word_r.pv && !out_word_r.eol)
  `WPF_ASSERT_NXT(a_split_record, pop && q_rec.has_emit && q_rec.has_fin, hold_r)
  `WPF_ASSERT_NXT(a_hold_kept, hold_r && out_stall, hold_r)

endmodule

// ===== hdl/waveform_peak_finder.sv =====
// top level of the waveform peak finder with its configuration registers
//
// Takes one sample word per clock, back to back, while in_stall is low, with
// no gaps needed between waveforms. The front end judges the middle of a
// three-sample window in the same cycle as the sample arrives and writes a
// record into a four-entry queue whenever a peak is emitted or the trailing
// guard arrives; the output stage shows a result word once its record has
// passed the queue slot and the output register. A trailing guard that both
// pushes out a peak and closes the list gives two words, one after the other,
// in the output register; the queue absorbs this, and in_stall only rises when
// the queue is full. Configuration writes are always taken (cfg_ready is tied
// high) and should only be made while no waveform is in flight.
module waveform_peak_finder #(
  parameter int MAX_PEAKS   = wpf_pkg::DEF_MAX_PEAKS,
  parameter int MAX_SAMPLES = wpf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = wpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_amplitude,
  input  logic signed [SAMPLE_BITS-1:0]        in_slope,
  input  logic signed [SAMPLE_BITS-1:0]        in_curvature,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_peak_valid,
  output logic [wpf_pkg::POS_W-1:0]            out_peak_position,
  output logic signed [wpf_pkg::HGT_W-1:0]     out_peak_height,
  output logic [wpf_pkg::CNT_W-1:0]            out_peak_count,
  output logic                                 out_end_of_list
);
  import wpf_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_full, q_pop, q_valid;
  rec_t  push_rec, q_rec;
  word_t out_word;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AMP_THR:   cfg_nxt.amp_thr   = cfg_data[14:0];
        REG_PROM_THR:  cfg_nxt.prom_thr  = cfg_data;
        REG_SLOPE_THR: cfg_nxt.slope_thr = cfg_data;
        REG_CURV_THR:  cfg_nxt.curv_thr  = cfg_data;
        REG_WIN_START: cfg_nxt.win_start = cfg_data[POS_W-1:0];
        REG_WIN_END:   cfg_nxt.win_end   = cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amp_thr   <= '0;
      cfg_r.prom_thr  <= '0;
      cfg_r.slope_thr <= '0;
      cfg_r.curv_thr  <= '0;
      cfg_r.win_start <= '0;
      cfg_r.win_end   <= WIN_END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wpf_front #(
    .MAX_PEAKS   (MAX_PEAKS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_amplitude (in_amplitude),
    .in_slope     (in_slope),
    .in_curvature (in_curvature),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  wpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  wpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_peak_valid    = out_word.pv;
  assign out_peak_position = out_word.pos;
  assign out_peak_height   = out_word.hgt;
  assign out_peak_count    = out_word.cnt;
  assign out_end_of_list   = out_word.eol;

endmodule
